[rtl/sfr_pkg.sv]
package sfr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 1024;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned TDATA_W = 32;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ADDR_BYTE = 8'h03;
	localparam logic [7:0] CTRL_SEQ0 = 8'h00;
	localparam logic [7:0] CTRL_SEQ1 = 8'h40;
	localparam logic [7:0] CTRL_DISC = 8'h0B;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;
	localparam logic [7:0] RR0       = 8'h05;
	localparam logic [7:0] RR1       = 8'h85;
	localparam logic [7:0] REJ0      = 8'h01;
	localparam logic [7:0] REJ1      = 8'h81;

	typedef enum logic [2:0] {
		K_PAYLOAD  = 3'd0,
		K_ACCEPT   = 3'd1,
		K_FAIL     = 3'd2,
		K_DUP      = 3'd3,
		K_DISC     = 3'd4,
		K_EMPTY    = 3'd5,
		K_OVERFLOW = 3'd6
	} kind_t;

	// One result as it waits in the queue; the reply byte is rebuilt from seq.
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic             seq;
		logic [LEN_W-1:0] len;
		logic             last;
	} cmd_t;

	// Up to two results written by the front in one cycle, c0 first.
	typedef struct packed {
		logic v0;
		logic v1;
		cmd_t c0;
		cmd_t c1;
	} push_t;

endpackage

[rtl/sfr_front.sv]
module sfr_front import sfr_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       take,
	output push_t      push
);

	localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [5:0] {
		PH_HUNT = 6'b000001,
		PH_FLAG = 6'b000010,
		PH_ADDR = 6'b000100,
		PH_CTRL = 6'b001000,
		PH_BODY = 6'b010000,
		PH_ESC  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0]    held;
		logic          hv;
		logic [7:0]    x;
		logic [CW-1:0] cnt;
	} body_t;

	typedef struct packed {
		body_t      st;
		logic       emit;
		logic       ovf;
		logic [7:0] data;
	} pres_t;

	phase_t phase_q, phase_d;
	logic   fseq_q, fseq_d;
	logic   eseq_q, eseq_d;
	body_t  body_q, body_d;
	pres_t  p1, p2;

	// A body byte is held back one place so that the trailing check byte never leaves.
	function automatic pres_t push_body(body_t s, logic [7:0] b);
		pres_t r;
		r = '0;
		r.st = s;
		if (s.hv) begin
			if (s.cnt >= CW'(MAX_PAYLOAD)) begin
				r.emit = 1'b1;
				r.ovf = 1'b1;
				r.st.hv = 1'b0;
			end else begin
				r.emit = 1'b1;
				r.data = s.held;
				r.st.x = s.x ^ s.held;
				r.st.cnt = s.cnt + 1'b1;
			end
		end
		if (!r.ovf) begin
			r.st.held = b;
			r.st.hv = 1'b1;
		end
		return r;
	endfunction

	function automatic cmd_t mk_cmd(kind_t k, logic [7:0] d, logic s, logic [LEN_W-1:0] l);
		cmd_t c;
		c.kind = k;
		c.data = d;
		c.seq = s;
		c.len = l;
		c.last = 1'b0;
		return c;
	endfunction

	function automatic cmd_t body_cmd(pres_t r);
		return mk_cmd(r.ovf ? K_OVERFLOW : K_PAYLOAD, r.data, 1'b0, '0);
	endfunction

	always_comb begin
		phase_d = phase_q;
		fseq_d = fseq_q;
		eseq_d = eseq_q;
		body_d = body_q;
		push = '0;
		p1 = '0;
		p2 = '0;
		unique case (phase_q)
			PH_HUNT: begin
				phase_d = (in_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
			end
			PH_FLAG: begin
				if (in_byte == ADDR_BYTE) begin
					phase_d = PH_ADDR;
				end else if (in_byte == FLAG_BYTE) begin
					push.v0 = 1'b1;
					push.c0 = mk_cmd(K_EMPTY, 8'h00, 1'b0, '0);
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_ADDR: begin
				if (in_byte == CTRL_SEQ0 || in_byte == CTRL_SEQ1) begin
					fseq_d = (in_byte == CTRL_SEQ1);
					phase_d = PH_CTRL;
				end else if (in_byte == CTRL_DISC) begin
					push.v0 = 1'b1;
					push.c0 = mk_cmd(K_DISC, 8'h00, 1'b0, '0);
					phase_d = PH_HUNT;
				end else if (in_byte == FLAG_BYTE) begin
					phase_d = PH_FLAG;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_CTRL: begin
				if (in_byte == (ADDR_BYTE ^ (fseq_q ? CTRL_SEQ1 : CTRL_SEQ0))) begin
					if (fseq_q == eseq_q) begin
						body_d = '0;
						phase_d = PH_BODY;
					end else begin
						push.v0 = 1'b1;
						push.c0 = mk_cmd(K_DUP, 8'h00, eseq_q, '0);
						phase_d = PH_HUNT;
					end
				end else if (in_byte == FLAG_BYTE) begin
					phase_d = PH_FLAG;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (in_byte == ESC_BYTE) begin
					phase_d = PH_ESC;
				end else if (in_byte == FLAG_BYTE) begin
					push.v0 = 1'b1;
					if (body_q.hv && body_q.held == body_q.x) begin
						eseq_d = ~eseq_q;
						push.c0 = mk_cmd(K_ACCEPT, 8'h00, ~eseq_q, LEN_W'(body_q.cnt));
					end else begin
						push.c0 = mk_cmd(K_FAIL, 8'h00, eseq_q, '0);
					end
					body_d.hv = 1'b0;
					phase_d = PH_HUNT;
				end else begin
					p1 = push_body(body_q, in_byte);
					body_d = p1.st;
					push.v0 = p1.emit;
					push.c0 = body_cmd(p1);
					if (p1.ovf) begin
						phase_d = PH_HUNT;
					end
				end
			end
			PH_ESC: begin
				phase_d = PH_BODY;
				if (in_byte == ESC_FLAG || in_byte == ESC_ESC) begin
					p1 = push_body(body_q, (in_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE);
					body_d = p1.st;
					push.v0 = p1.emit;
					push.c0 = body_cmd(p1);
					if (p1.ovf) begin
						phase_d = PH_HUNT;
					end
				end else begin
					// An unknown escape pair passes through as both bytes.
					p1 = push_body(body_q, ESC_BYTE);
					if (p1.ovf) begin
						body_d = p1.st;
						push.v0 = 1'b1;
						push.c0 = body_cmd(p1);
						phase_d = PH_HUNT;
					end else begin
						p2 = push_body(p1.st, in_byte);
						body_d = p2.st;
						if (p1.emit) begin
							push.v0 = 1'b1;
							push.c0 = body_cmd(p1);
							push.v1 = p2.emit;
							push.c1 = body_cmd(p2);
						end else begin
							push.v0 = p2.emit;
							push.c0 = body_cmd(p2);
						end
						if (p2.ovf) begin
							phase_d = PH_HUNT;
						end
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (push.v1) begin
			push.c1.last = 1'b1;
		end else if (push.v0) begin
			push.c0.last = 1'b1;
		end
		if (!take) begin
			push.v0 = 1'b0;
			push.v1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fseq_q <= 1'b0;
			eseq_q <= 1'b0;
			body_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			fseq_q <= fseq_d;
			eseq_q <= eseq_d;
			body_q <= body_d;
		end
	end

endmodule

[rtl/sfr_queue.sv]
module sfr_queue import sfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	input  logic  pop,
	output logic  head_valid,
	output cmd_t  head
);

	localparam int unsigned AW = $clog2(QDEPTH);
	localparam int unsigned CNT_W = AW + 1;

	cmd_t             mem_q [QDEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    wptr1;

	assign wptr1 = AW'(wptr_q + 1'b1);
	// Room for the worst case of two results from the next byte.
	assign room = (count_q <= CNT_W'(QDEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wptr_q] <= push.c0;
		end
		if (push.v1) begin
			mem_q[wptr1] <= push.c1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= AW'(wptr_q + CNT_W'(push.v0) + CNT_W'(push.v1));
			if (pop) begin
				rptr_q <= AW'(rptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop));
		end
	end

endmodule

[rtl/sfr_back.sv]
module sfr_back import sfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  cmd_t               head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast
);

	logic               tvalid_q;
	logic [TDATA_W-1:0] tdata_q;
	logic               tlast_q;
	logic               rv;
	logic [7:0]         rc;

	always_comb begin
		rv = 1'b0;
		rc = 8'h00;
		unique case (head.kind) inside
			K_ACCEPT, K_DUP: begin
				rv = 1'b1;
				rc = head.seq ? RR1 : RR0;
			end
			K_FAIL: begin
				rv = 1'b1;
				rc = head.seq ? REJ1 : REJ0;
			end
			default: begin
				rv = 1'b0;
				rc = 8'h00;
			end
		endcase
	end

	assign pop = head_valid && (!tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (pop) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= TDATA_W'({head.len, rc, rv, head.data, head.kind});
			tlast_q <= head.last;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata = tdata_q;
	assign m_tlast = tlast_q;

endmodule

[rtl/stuffed_frame_receiver.sv]
// Byte-stuffed frame receiver with stop-and-wait sequencing. It takes one line byte per
// cycle on the slave side while the queue has room and writes up to two results per
// byte into a four-entry queue; the master side drains the queue through an output
// register at one result per cycle while m_tready is high. Each result passes through
// the queue and then the output register. The slave side is ready whenever the queue
// has room for two results, so a steady stream of one byte per cycle runs without
// stalls while the master side keeps up; a byte that ends an unknown escape pair can
// make two results, and the output rate of one result per cycle then sets the pace.
// Payload bytes leave one byte late so that the trailing check byte is never passed on.
module stuffed_frame_receiver import sfr_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	// [2:0] kind, [10:3] data_byte, [11] reply_valid, [19:12] reply_control,
	// [30:20] frame_length, [31] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast
);

	push_t push;
	logic  room;
	logic  pop;
	logic  head_valid;
	cmd_t  head;

	assign s_tready = room;

	sfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_byte(s_tdata),
		.take   (s_tvalid && room),
		.push   (push)
	);

	sfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

[rtl/sfr_checker.sv]
module sfr_checker import sfr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	logic [2:0] kind;

	assign kind = m_tdata[2:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transfer changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> kind <= K_OVERFLOW)
		else $error("undefined result kind");

	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11] == (kind == K_ACCEPT || kind == K_FAIL || kind == K_DUP))
		else $error("reply flag does not match result kind");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != K_PAYLOAD |-> m_tlast && m_tdata[10:3] == 8'h00)
		else $error("status result is not the last of its byte or carries data");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != K_ACCEPT |-> m_tdata[30:20] == '0)
		else $error("frame length set outside an accepted frame");

endmodule

bind stuffed_frame_receiver sfr_checker u_checker (.*);
